// ----- hdl/ncc_pkg.sv -----
// Package with the sizes shared by the normalized cross-correlation block.
package ncc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LEN     = 4096;
    localparam int SUM_W       = 48;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);
    localparam int HALF_W      = SUM_W / 2;
    localparam int PROD_W      = 2 * SUM_W;
    localparam int WIDE_W      = 128;
    localparam int Q_W         = 16;
    localparam int NORM_W      = 16;
    localparam int FRAC_SH     = 30;
    localparam int BIT_W       = $clog2(Q_W);
    localparam int STEP_W      = 4;
    localparam int MAG_W       = SAMPLE_BITS + 1;
    localparam int S_DATA_W    = 2 * SAMPLE_BITS;
    localparam int M_DATA_W    = SUM_W + NORM_W;
    localparam int M_USER_W    = 2;

endpackage

// ----- hdl/normalized_cross_correlation.sv -----
// Normalized cross-correlation: running sums, shared multiplier and root/divide sequencer.
// Each pair passes through its transfer, three products on the shared 24x24 multiplier and
// a final add, the input held off meanwhile; past MAX_LEN a pair is dropped at its transfer.
// A last pair adds setup, the partial products of the two wide products, the root-quotient
// search (S_SQ_A, S_SQ_B per bit) and the hand-off; zero energy skips straight to hand-off.
// Reset is synchronous, active low, and clears the sums, the pair counter, the overflow flag and the output valid.
module normalized_cross_correlation (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // x_sample [15:0], y_sample [31:16]
    input  logic [ncc_pkg::S_DATA_W-1:0]    i_s_tdata,
    // last_sample
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // dot_product [47:0], norm_corr [63:48]
    output logic [ncc_pkg::M_DATA_W-1:0]    o_m_tdata,
    // zero_energy [0], length_overflow [1]
    output logic [ncc_pkg::M_USER_W-1:0]    o_m_tuser
);
    import ncc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ACC_XY, S_ACC_XX, S_ACC_YY, S_ACC_ADD,
        S_FIN, S_MUL, S_SQ_INIT, S_SQ_A, S_SQ_B, S_DONE
    } t_state;

    t_state                  r_state;
    logic [SUM_W-1:0]        r_cross, r_xe, r_ye;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;
    logic [MAG_W-1:0]        r_xm, r_ym;
    logic                    r_xs, r_ys, r_last;
    logic [SUM_W-1:0]        r_prod;
    logic [SUM_W-1:0]        r_mag;
    logic                    r_neg, r_zero;
    logic [STEP_W-1:0]       r_step;
    logic                    r_pend, r_ptag_r;
    logic [1:0]              r_ptag_sh;
    logic [PROD_W-1:0]       r_p, r_r;
    logic [WIDE_W-1:0]       r_d, r_t, r_c, r_tn;
    logic [BIT_W-1:0]        r_bit;
    logic [Q_W-1:0]          r_q;
    logic                    r_mvalid;
    logic [SUM_W-1:0]        r_dot_o;
    logic [NORM_W-1:0]       r_norm_o;
    logic                    r_zero_o, r_ovf_o;

    logic [HALF_W-1:0]       mul_a, mul_b;
    logic [SUM_W-1:0]        n_prod;
    logic [PROD_W-1:0]       part_w;
    logic [WIDE_W-1:0]       p_w;
    logic [WIDE_W:0]         diff;
    logic [MAG_W-1:0]        x_ext, y_ext;
    logic [Q_W-1:0]          q_clamp;
    logic [NORM_W-1:0]       norm;
    logic [1:0]              part_idx;
    logic                    out_free;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = {r_norm_o, r_dot_o};
    assign o_m_tuser  = {r_ovf_o, r_zero_o};
    assign out_free   = !r_mvalid || i_m_tready;

    assign x_ext    = {i_s_tdata[SAMPLE_BITS-1], i_s_tdata[SAMPLE_BITS-1:0]};
    assign y_ext    = {i_s_tdata[S_DATA_W-1], i_s_tdata[S_DATA_W-1:SAMPLE_BITS]};
    assign part_idx = r_step[1:0];
    assign p_w      = {{(WIDE_W - PROD_W){1'b0}}, r_p};

    // Operand selection for the shared multiplier. During the wide products the step
    // counter walks four 24-bit partial products for xe*ye and then four for mag*mag.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_ACC_XY: begin
                mul_a = HALF_W'(r_xm);
                mul_b = HALF_W'(r_ym);
            end
            S_ACC_XX: begin
                mul_a = HALF_W'(r_xm);
                mul_b = HALF_W'(r_xm);
            end
            S_ACC_YY: begin
                mul_a = HALF_W'(r_ym);
                mul_b = HALF_W'(r_ym);
            end
            S_MUL: begin
                if (r_step[2]) begin
                    mul_a = part_idx[1] ? r_mag[SUM_W-1:HALF_W] : r_mag[HALF_W-1:0];
                    mul_b = part_idx[0] ? r_mag[SUM_W-1:HALF_W] : r_mag[HALF_W-1:0];
                end else begin
                    mul_a = part_idx[1] ? r_xe[SUM_W-1:HALF_W] : r_xe[HALF_W-1:0];
                    mul_b = part_idx[0] ? r_ye[SUM_W-1:HALF_W] : r_ye[HALF_W-1:0];
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

    always_comb begin
        case (r_ptag_sh)
            2'd0:    part_w = {{SUM_W{1'b0}}, r_prod};
            2'd1:    part_w = {{HALF_W{1'b0}}, r_prod, {HALF_W{1'b0}}};
            default: part_w = {r_prod, {SUM_W{1'b0}}};
        endcase
    end

    assign diff = {1'b0, r_d} - {1'b0, r_c};

    // The search may settle above full scale; the quotient is bounded by one.
    always_comb begin
        q_clamp = (r_q > Q_W'(32768)) ? Q_W'(32768) : r_q;
        if (r_zero) begin
            norm = '0;
        end else if (r_neg) begin
            norm = NORM_W'(Q_W'(0) - q_clamp);
        end else begin
            norm = (q_clamp > Q_W'(32767)) ? NORM_W'(32767) : NORM_W'(q_clamp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cross  <= '0;
            r_xe     <= '0;
            r_ye     <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_mvalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            // The hand-off state loads the result register itself.
            if (i_m_tready && r_state != S_DONE) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_xs   <= x_ext[MAG_W-1];
                        r_ys   <= y_ext[MAG_W-1];
                        r_xm   <= x_ext[MAG_W-1] ? (MAG_W'(0) - x_ext) : x_ext;
                        r_ym   <= y_ext[MAG_W-1] ? (MAG_W'(0) - y_ext) : y_ext;
                        r_last <= i_s_tlast;
                        if (r_count < CNT_W'(MAX_LEN)) begin
                            r_state <= S_ACC_XY;
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= i_s_tlast ? S_FIN : S_IDLE;
                        end
                    end
                end
                S_ACC_XY: begin
                    r_prod  <= n_prod;
                    r_state <= S_ACC_XX;
                end
                S_ACC_XX: begin
                    r_cross <= r_cross + ((r_xs ^ r_ys) ? (SUM_W'(0) - r_prod) : r_prod);
                    r_prod  <= n_prod;
                    r_state <= S_ACC_YY;
                end
                S_ACC_YY: begin
                    r_xe    <= r_xe + r_prod;
                    r_prod  <= n_prod;
                    r_state <= S_ACC_ADD;
                end
                S_ACC_ADD: begin
                    r_ye    <= r_ye + r_prod;
                    r_count <= r_count + CNT_W'(1);
                    r_state <= r_last ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_neg <= r_cross[SUM_W-1];
                    r_mag <= r_cross[SUM_W-1] ? (SUM_W'(0) - r_cross) : r_cross;
                    r_q   <= '0;
                    if (r_xe == '0 || r_ye == '0) begin
                        r_zero  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_zero  <= 1'b0;
                        r_p     <= '0;
                        r_r     <= '0;
                        r_step  <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Each cycle multiplies one partial and adds the previous one in; the last step only adds.
                    if (r_pend) begin
                        if (r_ptag_r) begin
                            r_r <= r_r + part_w;
                        end else begin
                            r_p <= r_p + part_w;
                        end
                    end
                    if (!r_step[3]) begin
                        r_prod    <= n_prod;
                        r_ptag_r  <= r_step[2];
                        r_ptag_sh <= 2'(part_idx[1]) + 2'(part_idx[0]);
                        r_pend    <= 1'b1;
                        r_step    <= r_step + STEP_W'(1);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_SQ_INIT;
                    end
                end
                S_SQ_INIT: begin
                    r_d     <= {{(WIDE_W - PROD_W - FRAC_SH){1'b0}}, r_r, {FRAC_SH{1'b0}}};
                    r_t     <= '0;
                    r_bit   <= BIT_W'(Q_W - 1);
                    r_state <= S_SQ_A;
                end
                S_SQ_A: begin
                    // Growth of q*q*p when bit k of q is set: 2^(k+1)*q*p + 2^(2k)*p.
                    r_c     <= (r_t << ({1'b0, r_bit} + 5'd1)) + (p_w << {r_bit, 1'b0});
                    r_tn    <= r_t + (p_w << r_bit);
                    r_state <= S_SQ_B;
                end
                S_SQ_B: begin
                    if (!diff[WIDE_W]) begin
                        r_d          <= diff[WIDE_W-1:0];
                        r_t          <= r_tn;
                        r_q[r_bit]   <= 1'b1;
                    end
                    if (r_bit == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_bit   <= r_bit - BIT_W'(1);
                        r_state <= S_SQ_A;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_mvalid <= 1'b1;
                        r_dot_o  <= r_cross;
                        r_norm_o <= norm;
                        r_zero_o <= r_zero;
                        r_ovf_o  <= r_ovf;
                        r_cross  <= '0;
                        r_xe     <= '0;
                        r_ye     <= '0;
                        r_count  <= '0;
                        r_ovf    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- dv/normalized_cross_correlation_tb.sv -----
// Self-checking testbench for the normalized cross-correlation block.
module normalized_cross_correlation_tb;
    import ncc_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        logic signed [SUM_W-1:0]  dot;
        logic signed [NORM_W-1:0] corr;
        logic                     zero;
        logic                     ovf;
    } t_corr_result;

    typedef struct {
        int           x;
        int           y;
        bit           last;
        int           reps;
        bit           typed;
        t_corr_result want;
    } t_stim_row;

    typedef enum {MIX_WIDE, MIX_SMALL, MIX_TRACK, MIX_RAIL, MIX_NO_X, MIX_NO_Y} t_vec_mix;

    localparam int N_ROWS         = 22;
    localparam int RANDOM_ITEMS   = 1420;
    localparam int RX_HOLD_CYCLES = 800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // x_sample [15:0], y_sample [31:16]
    logic [S_DATA_W-1:0]   i_s_tdata = '0;
    // last_sample
    logic                  i_s_tlast = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // dot_product [47:0], norm_corr [63:48]
    logic [M_DATA_W-1:0]   o_m_tdata;
    // zero_energy [0], length_overflow [1]
    logic [M_USER_W-1:0]   o_m_tuser;

    // Running sums of the model of the block.
    logic [SUM_W-1:0] sum_xy = '0;
    logic [SUM_W-1:0] sum_xx = '0;
    logic [SUM_W-1:0] sum_yy = '0;
    int               pairs_held = 0;
    bit               length_exceeded = 1'b0;

    t_corr_result awaited_results[$];
    int           mismatches = 0;
    bit           calm = 1'b0;
    bit           stall_request = 1'b0;
    int           quiet_cycles = 0;

    // Hand-checked rows carry their result; the others go through the model.
    t_stim_row directed_rows [N_ROWS] = '{
        '{ 32767,  32767, 1, 1,    1, '{1073676289, 32767, 0, 0}},
        '{-32768,  32767, 1, 1,    1, '{-1073709056, -32768, 0, 0}},
        '{-32768, -32768, 1, 1,    1, '{1073741824, 32767, 0, 0}},
        '{ 32767, -32768, 1, 1,    1, '{-1073709056, -32768, 0, 0}},
        '{     0,   1234, 1, 1,    1, '{0, 0, 1, 0}},
        '{    -5,      0, 1, 1,    1, '{0, 0, 1, 0}},
        '{     0,      0, 1, 1,    1, '{0, 0, 1, 0}},
        '{     7,      0, 0, 1,    0, '{0, 0, 0, 0}},
        '{    -9,      0, 1, 1,    1, '{0, 0, 1, 0}},
        '{     1,      1, 0, 1,    0, '{0, 0, 0, 0}},
        '{     1,     -1, 1, 1,    1, '{0, 0, 0, 0}},
        '{   100,      3, 0, 1,    0, '{0, 0, 0, 0}},
        '{  -200,     50, 0, 1,    0, '{0, 0, 0, 0}},
        '{     1, -32768, 0, 1,    0, '{0, 0, 0, 0}},
        '{ 32767,  12345, 1, 1,    0, '{0, 0, 0, 0}},
        '{ 21845, -21846, 0, 1,    0, '{0, 0, 0, 0}},
        '{-21846,  21845, 1, 1,    0, '{0, 0, 0, 0}},
        '{     2,     -3, 0, 99,   0, '{0, 0, 0, 0}},
        '{     2,     -3, 1, 1,    1, '{-600, -32768, 0, 0}},
        '{     1,      1, 0, 9,    0, '{0, 0, 0, 0}},
        '{-32768,  32767, 1, 1,    0, '{0, 0, 0, 0}},
        '{     3,      4, 1, 1,    1, '{12, 32767, 0, 0}}
    };

    normalized_cross_correlation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic int idle_pct();
        return calm ? 0 : 30;
    endfunction

    // Largest q in [0, 32768] with q*q*xx*yy <= xy*xy*2^30, then signed and clamped.
    function automatic logic [NORM_W-1:0] q15_ratio(input logic [SUM_W-1:0] xy,
                                                    input logic [SUM_W-1:0] xx,
                                                    input logic [SUM_W-1:0] yy);
        logic [191:0]     energy;
        logic [191:0]     bound;
        logic [191:0]     trial;
        logic [SUM_W-1:0] mag;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        mag    = xy[SUM_W-1] ? (~xy + 1'b1) : xy;
        energy = 192'(xx) * 192'(yy);
        bound  = (192'(mag) * 192'(mag)) << FRAC_SH;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid   = (lo + hi + 1) / 2;
            trial = 192'(mid * mid) * energy;
            if (trial <= bound) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (xy[SUM_W-1]) begin
            return -lo[NORM_W-1:0];
        end
        return (lo > 32767) ? NORM_W'(32767) : lo[NORM_W-1:0];
    endfunction

    // Folds one pair into the sums; returns 1 with the result when the pair closes a vector.
    function automatic bit fold_pair(input t_sample x, input t_sample y, input bit last,
                                     output t_corr_result res);
        logic signed [31:0] pxy;
        logic signed [31:0] pxx;
        logic signed [31:0] pyy;
        res = '0;
        if (pairs_held < MAX_LEN) begin
            pxy = x * y;
            pxx = x * x;
            pyy = y * y;
            sum_xy = sum_xy + {{(SUM_W-32){pxy[31]}}, pxy};
            sum_xx = sum_xx + {{(SUM_W-32){1'b0}}, pxx};
            sum_yy = sum_yy + {{(SUM_W-32){1'b0}}, pyy};
            pairs_held++;
        end else begin
            length_exceeded = 1'b1;
        end
        if (!last) begin
            return 1'b0;
        end
        res.dot = sum_xy;
        res.ovf = length_exceeded;
        if (sum_xx == '0 || sum_yy == '0) begin
            res.zero = 1'b1;
        end else begin
            res.corr = q15_ratio(sum_xy, sum_xx, sum_yy);
        end
        sum_xy = '0;
        sum_xx = '0;
        sum_yy = '0;
        pairs_held = 0;
        length_exceeded = 1'b0;
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the next falling edge after the transfer.
    task automatic offer_pair(input t_sample x, input t_sample y, input bit last,
                              input bit typed, input t_corr_result typed_res);
        t_corr_result res;
        while ($urandom_range(99) < idle_pct()) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        if (fold_pair(x, y, last, res)) begin
            awaited_results.push_back(typed ? typed_res : res);
        end
        @(negedge i_clk);
    endtask

    // Result side: random back-pressure plus one long hold when requested.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= idle_pct());
        end
    end

    always @(posedge i_clk) begin
        t_corr_result got;
        t_corr_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.dot  = o_m_tdata[SUM_W-1:0];
            got.corr = o_m_tdata[SUM_W +: NORM_W];
            got.zero = o_m_tuser[0];
            got.ovf  = o_m_tuser[1];
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: result transfer with none expected, dot %0d corr %0d",
                         $time, got.dot, got.corr);
            end else begin
                want = awaited_results.pop_front();
                if (got.dot !== want.dot) begin
                    mismatches++;
                    $display("%0t: dot_product expected %0d got %0d", $time, want.dot, got.dot);
                end
                if (got.corr !== want.corr) begin
                    mismatches++;
                    $display("%0t: norm_corr expected %0d got %0d", $time, want.corr, got.corr);
                end
                if (got.zero !== want.zero) begin
                    mismatches++;
                    $display("%0t: zero_energy expected %0b got %0b", $time, want.zero,
                             got.zero);
                end
                if (got.ovf !== want.ovf) begin
                    mismatches++;
                    $display("%0t: length_overflow expected %0b got %0b", $time, want.ovf,
                             got.ovf);
                end
            end
        end
    end

    // Ends the run if neither side moves a transfer for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int       sent;
        int       len;
        int       pick;
        bit       flip;
        bit       held_once;
        bit       paused_once;
        t_vec_mix mix;
        t_sample  x;
        t_sample  y;
        sent = 0;
        held_once = 1'b0;
        paused_once = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            for (int r = 0; r < directed_rows[i].reps; r++) begin
                offer_pair(SAMPLE_BITS'(directed_rows[i].x), SAMPLE_BITS'(directed_rows[i].y),
                           directed_rows[i].last && (r == directed_rows[i].reps - 1),
                           directed_rows[i].typed, directed_rows[i].want);
            end
        end

        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 500 && sent < 800);
            if (!held_once && sent >= 250) begin
                held_once = 1'b1;
                stall_request = 1'b1;
            end
            if (!paused_once && sent >= 1000) begin
                paused_once = 1'b1;
                i_s_tvalid <= 1'b0;
                while (awaited_results.size() != 0) @(negedge i_clk);
            end
            pick = $urandom_range(99);
            len = (pick < 70) ? $urandom_range(8, 1) :
                  (pick < 95) ? $urandom_range(40, 9) : $urandom_range(200, 41);
            pick = $urandom_range(99);
            mix = (pick < 35) ? MIX_WIDE : (pick < 55) ? MIX_SMALL : (pick < 75) ? MIX_TRACK :
                  (pick < 85) ? MIX_RAIL : (pick < 93) ? MIX_NO_X : MIX_NO_Y;
            flip = $urandom_range(1);
            for (int k = 0; k < len; k++) begin
                x = SAMPLE_BITS'($urandom);
                y = SAMPLE_BITS'($urandom);
                case (mix)
                    MIX_SMALL: begin
                        x = SAMPLE_BITS'(int'($urandom_range(15)) - 8);
                        y = SAMPLE_BITS'(int'($urandom_range(15)) - 8);
                    end
                    // Nearly parallel vectors push the ratio toward the rails.
                    MIX_TRACK: begin
                        y = (flip ? -x : x) + SAMPLE_BITS'(int'($urandom_range(6)) - 3);
                    end
                    MIX_RAIL: begin
                        x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                        y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    end
                    MIX_NO_X: x = '0;
                    MIX_NO_Y: y = '0;
                    default: ;
                endcase
                offer_pair(x, y, k == len - 1, 1'b0, '0);
                sent++;
            end
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;

        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
